// File: hw/rtl/kcl_pkg.sv
// Shared types, codes and sizes for the keypad code lock.
`timescale 1ns / 1ps

package kcl_pkg;

  // Code length limits
  localparam int MaxDigits = 6;
  localparam int MinDigits = 4;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int IdxW      = $clog2(MaxDigits);

  // Field widths
  localparam int KeyW   = 4;
  localparam int EventW = 4;
  localparam int RetryW = 3;
  localparam int ModeW  = 3;

  // Length keys accepted in the choose-length step
  localparam int LenKeyLo = (MinDigits > 4) ? MinDigits : 4;
  localparam int LenKeyHi = (MaxDigits < 6) ? MaxDigits : 6;

  localparam logic [RetryW-1:0] RetryMax        = 3'd7;
  localparam logic [RetryW-1:0] RetryLimitReset = 3'd3;

  // Key codes
  localparam logic [KeyW-1:0] KeyDigitMax = 4'd9;
  localparam logic [KeyW-1:0] KeyA        = 4'd10;
  localparam logic [KeyW-1:0] KeyStar     = 4'd14;
  localparam logic [KeyW-1:0] KeyHash     = 4'd15;

  // Result events
  localparam logic [EventW-1:0] EvIgnored  = 4'd0;
  localparam logic [EventW-1:0] EvDigit    = 4'd1;
  localparam logic [EventW-1:0] EvErased   = 4'd2;
  localparam logic [EventW-1:0] EvGranted  = 4'd3;
  localparam logic [EventW-1:0] EvWrong    = 4'd4;
  localparam logic [EventW-1:0] EvAlarm    = 4'd5;
  localparam logic [EventW-1:0] EvOldBad   = 4'd6;
  localparam logic [EventW-1:0] EvSaved    = 4'd7;
  localparam logic [EventW-1:0] EvMismatch = 4'd8;
  localparam logic [EventW-1:0] EvChange   = 4'd9;
  localparam logic [EventW-1:0] EvLength   = 4'd10;
  localparam logic [EventW-1:0] EvConfirm  = 4'd11;
  localparam logic [EventW-1:0] EvLogin    = 4'd12;

  // Lock modes (state codes)
  localparam logic [ModeW-1:0] ModeMenu  = 3'd0;
  localparam logic [ModeW-1:0] ModeLogin = 3'd1;
  localparam logic [ModeW-1:0] ModeOld   = 3'd2;
  localparam logic [ModeW-1:0] ModeLen   = 3'd3;
  localparam logic [ModeW-1:0] ModeNew   = 3'd4;
  localparam logic [ModeW-1:0] ModeConf  = 3'd5;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    KcDigit,
    KcLenKey,
    KcA,
    KcStar,
    KcHash,
    KcOther
  } key_class_e;

  // Classified key word
  typedef struct packed {
    key_class_e      cls;
    logic [KeyW-1:0] key;
  } kcl_word_t;

  typedef logic [MaxDigits-1:0][KeyW-1:0] code_t;

endpackage

// File: hw/rtl/kcl_front.sv
// Front end: accepts keypad words and classifies them for the back end.
`timescale 1ns / 1ps

module kcl_front import kcl_pkg::*; (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [KeyW-1:0] key_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output kcl_word_t       q_word_o
);

  key_class_e cls;

  // Key classification; digits in the length range are tagged separately
  always_comb begin
    cls = KcOther;
    if (key_i <= KeyDigitMax) begin
      if (int'(key_i) >= LenKeyLo && int'(key_i) <= LenKeyHi) begin
        cls = KcLenKey;
      end else begin
        cls = KcDigit;
      end
    end else if (key_i == KeyA) begin
      cls = KcA;
    end else if (key_i == KeyStar) begin
      cls = KcStar;
    end else if (key_i == KeyHash) begin
      cls = KcHash;
    end
  end

  // Accept whenever the queue has room
  assign in_stall_o   = q_full_i;
  assign q_push_o     = in_valid_i & ~q_full_i;
  assign q_word_o.cls = cls;
  assign q_word_o.key = key_i;

endmodule

// File: hw/rtl/kcl_queue.sv
// Short word queue between the front and back ends.
`timescale 1ns / 1ps

module kcl_queue import kcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  kcl_word_t word_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output kcl_word_t word_o
);

  kcl_word_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign word_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

// File: hw/rtl/kcl_exec.sv
// Back end: lock state machine, code storage and result register.
`timescale 1ns / 1ps

module kcl_exec import kcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RetryW-1:0] cfg_wdata_i,
  input  logic              q_empty_i,
  input  kcl_word_t         q_word_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [EventW-1:0] event_res_o,
  output logic [RetryW-1:0] retry_count_o,
  output logic [CntW-1:0]   entry_count_o,
  output logic [ModeW-1:0]  mode_o
);

  logic [RetryW-1:0] retry_limit_q;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [CntW-1:0]   entry_len_q, entry_len_d;
  logic [CntW-1:0]   stored_len_q, stored_len_d;
  logic [CntW-1:0]   new_len_q, new_len_d;
  logic [RetryW-1:0] retries_q, retries_d;
  code_t             entry_q, stored_q, new_q;

  logic              out_valid_q;
  logic [EventW-1:0] ev_q;
  logic [RetryW-1:0] shown_q;
  logic [CntW-1:0]   cnt_out_q;
  logic [ModeW-1:0]  mode_out_q;

  logic [EventW-1:0] ev;
  logic [RetryW-1:0] shown;
  logic [RetryW-1:0] retries_inc;
  logic [CntW-1:0]   target;
  logic              entry_wr, save_new, save_stored;
  logic              match_stored, match_new;

  // First target digits of a code equal to the entry buffer
  function automatic logic same_digits(code_t a, code_t b, logic [CntW-1:0] n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MaxDigits; i++) begin
      if (CntW'(i) < n && a[i] != b[i]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Take a word when the result register is free or being emptied
  assign q_pop_o = ~q_empty_i & (~out_valid_q | ~out_stall_i);

  assign target       = (mode_q == ModeNew || mode_q == ModeConf) ? new_len_q : stored_len_q;
  assign match_stored = same_digits(stored_q, entry_q, target);
  assign match_new    = same_digits(new_q, entry_q, target);
  assign retries_inc  = (retries_q < RetryMax) ? retries_q + 1'b1 : retries_q;

  // Next state for one key
  always_comb begin
    mode_d       = mode_q;
    entry_len_d  = entry_len_q;
    stored_len_d = stored_len_q;
    new_len_d    = new_len_q;
    retries_d    = retries_q;
    ev           = EvIgnored;
    entry_wr     = 1'b0;
    save_new     = 1'b0;
    save_stored  = 1'b0;
    case (mode_q)
      ModeMenu: begin
        if (q_word_i.cls == KcA) begin
          mode_d      = ModeOld;
          entry_len_d = '0;
          ev          = EvChange;
        end else if (q_word_i.cls == KcHash) begin
          mode_d      = ModeLogin;
          entry_len_d = '0;
          ev          = EvLogin;
        end
      end
      ModeLen: begin
        if (q_word_i.cls == KcLenKey) begin
          new_len_d   = CntW'(q_word_i.key);
          entry_len_d = '0;
          mode_d      = ModeNew;
          ev          = EvLength;
        end
      end
      ModeLogin, ModeOld, ModeNew, ModeConf: begin
        if (q_word_i.cls == KcDigit || q_word_i.cls == KcLenKey) begin
          if (entry_len_q < target && entry_len_q < CntW'(MaxDigits)) begin
            entry_wr    = 1'b1;
            entry_len_d = entry_len_q + 1'b1;
            ev          = EvDigit;
          end
        end else if (q_word_i.cls == KcStar) begin
          if (entry_len_q != '0) begin
            entry_len_d = entry_len_q - 1'b1;
            ev          = EvErased;
          end
        end else if (q_word_i.cls == KcHash && entry_len_q >= target) begin
          entry_len_d = '0;
          case (mode_q)
            ModeLogin: begin
              mode_d = ModeMenu;
              if (match_stored) begin
                retries_d = '0;
                ev        = EvGranted;
              end else begin
                retries_d = retries_inc;
                ev        = (retries_inc >= retry_limit_q) ? EvAlarm : EvWrong;
              end
            end
            ModeOld: begin
              if (match_stored) begin
                mode_d = ModeLen;
                ev     = EvChange;
              end else begin
                mode_d = ModeMenu;
                ev     = EvOldBad;
              end
            end
            ModeNew: begin
              save_new = 1'b1;
              mode_d   = ModeConf;
              ev       = EvConfirm;
            end
            default: begin
              mode_d = ModeMenu;
              if (match_new) begin
                save_stored  = 1'b1;
                stored_len_d = target;
                ev           = EvSaved;
              end else begin
                ev = EvMismatch;
              end
            end
          endcase
        end
      end
      default: begin
        mode_d = ModeMenu;
      end
    endcase
    // Alarm shows the count reached, then clears it
    shown = retries_d;
    if (ev == EvAlarm) begin
      retries_d = '0;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RetryLimitReset;
      mode_q        <= ModeMenu;
      entry_len_q   <= '0;
      stored_len_q  <= CntW'(4);
      new_len_q     <= '0;
      retries_q     <= '0;
      stored_q      <= code_t'({KeyW'(4), KeyW'(3), KeyW'(2), KeyW'(1)});
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        retry_limit_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        mode_q       <= mode_d;
        entry_len_q  <= entry_len_d;
        stored_len_q <= stored_len_d;
        new_len_q    <= new_len_d;
        retries_q    <= retries_d;
        if (save_stored) begin
          stored_q <= new_q;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Entry and new-code buffers, result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (entry_wr) begin
        entry_q[entry_len_q[IdxW-1:0]] <= q_word_i.key;
      end
      if (save_new) begin
        new_q <= entry_q;
      end
      ev_q       <= ev;
      shown_q    <= shown;
      cnt_out_q  <= entry_len_d;
      mode_out_q <= mode_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign retry_count_o = shown_q;
  assign entry_count_o = cnt_out_q;
  assign mode_o        = mode_out_q;

endmodule

// File: hw/rtl/keypad_code_lock.sv
// Keypad code lock top level: front end, word queue and lock back end.
//
// Usage: each input word is one decoded key (key_i) on a valid/stall channel;
// the word is taken at a rising edge with in_valid_i high and in_stall_o low.
// Every key gives exactly one result word on the output channel: event code,
// retry count, digits in the entry buffer and the lock mode after the key.
// The user must write the retry limit register with cfg_we_i/cfg_wdata_i
// only while idle; the block itself does not enforce it. Throughput: one
// key per cycle while the receiver does not stall. A taken key is written
// into the queue; the state update then loads its result word.
// The two-word queue lets the front keep taking keys while the receiver
// stalls; in_stall_o rises once the queue is full and the result register
// still holds an untaken word.
// Reset: lock in the menu, stored code 1234 (four digits), retries 0,
// retry limit 3, queue and result register empty.
`timescale 1ns / 1ps

module keypad_code_lock import kcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RetryW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KeyW-1:0]   key_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [EventW-1:0] event_res_o,
  output logic [RetryW-1:0] retry_count_o,
  output logic [CntW-1:0]   entry_count_o,
  output logic [ModeW-1:0]  mode_o
);

  logic      q_full, q_empty, q_push, q_pop;
  kcl_word_t q_wr_word, q_rd_word;

  // Classification
  kcl_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .key_i      (key_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (q_wr_word)
  );

  // Decoupling queue
  kcl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (q_wr_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .word_o  (q_rd_word)
  );

  // Lock state and results
  kcl_exec u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_empty_i     (q_empty),
    .q_word_i      (q_rd_word),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .retry_count_o (retry_count_o),
    .entry_count_o (entry_count_o),
    .mode_o        (mode_o)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keypad code lock: directed key table, then random sessions.

module tb;
  import kcl_pkg::*;

  // One result word as the lock reports it
  typedef struct packed {
    logic [EventW-1:0] ev;
    logic [RetryW-1:0] retries;
    logic [CntW-1:0]   entries;
    logic [ModeW-1:0]  mode;
  } lock_word_t;

  // Directed row: key, whether the result is spelled out, and that result
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            typed;
    lock_word_t      want;
  } key_row_t;

  localparam int QuietLimit  = 2000;
  localparam int NumKeyRows  = 30;
  localparam int NumPhases   = 6;
  localparam int PhaseWords  = 250;

  // Login with a wrong code, then a full code change to 0909
  localparam key_row_t KeyRows [NumKeyRows] = '{
    '{4'd0,    1'b1, '{EvIgnored, 3'd0, 3'd0, ModeMenu}},
    '{KeyHash, 1'b1, '{EvLogin,   3'd0, 3'd0, ModeLogin}},
    '{KeyStar, 1'b1, '{EvIgnored, 3'd0, 3'd0, ModeLogin}},
    '{4'd9,    1'b0, '0},
    '{KeyHash, 1'b1, '{EvIgnored, 3'd0, 3'd1, ModeLogin}},
    '{KeyStar, 1'b1, '{EvErased,  3'd0, 3'd0, ModeLogin}},
    '{4'd9,    1'b0, '0},
    '{4'd8,    1'b0, '0},
    '{4'd7,    1'b0, '0},
    '{4'd6,    1'b0, '0},
    '{4'd0,    1'b1, '{EvIgnored, 3'd0, 3'd4, ModeLogin}},
    '{KeyHash, 1'b1, '{EvWrong,   3'd1, 3'd0, ModeMenu}},
    '{KeyA,    1'b1, '{EvChange,  3'd1, 3'd0, ModeOld}},
    '{4'd1,    1'b0, '0},
    '{4'd2,    1'b0, '0},
    '{4'd3,    1'b0, '0},
    '{4'd4,    1'b0, '0},
    '{KeyHash, 1'b1, '{EvChange,  3'd1, 3'd0, ModeLen}},
    '{4'd7,    1'b1, '{EvIgnored, 3'd1, 3'd0, ModeLen}},
    '{4'd4,    1'b0, '0},
    '{4'd0,    1'b0, '0},
    '{4'd9,    1'b0, '0},
    '{4'd0,    1'b0, '0},
    '{4'd9,    1'b0, '0},
    '{KeyHash, 1'b1, '{EvConfirm, 3'd1, 3'd0, ModeConf}},
    '{4'd0,    1'b0, '0},
    '{4'd9,    1'b0, '0},
    '{4'd0,    1'b0, '0},
    '{4'd9,    1'b0, '0},
    '{KeyHash, 1'b1, '{EvSaved,   3'd1, 3'd0, ModeMenu}}
  };

  // Per phase: retry limit, share of logins with the right code
  localparam logic [RetryW-1:0] PhaseLimit [NumPhases] = '{3'd1, 3'd7, 3'd0, 3'd5, 3'd6, 3'd2};
  localparam int PhaseGrant [NumPhases] = '{50, 10, 50, 20, 15, 40};
  // Idle profiles, two phases each
  localparam int SendIdle  [3] = '{33, 51, 0};
  localparam int RecvStall [3] = '{51, 33, 0};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [RetryW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [KeyW-1:0]   key_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [EventW-1:0] event_res_o;
  logic [RetryW-1:0] retry_count_o;
  logic [CntW-1:0]   entry_count_o;
  logic [ModeW-1:0]  mode_o;

  keypad_code_lock dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .retry_count_o (retry_count_o),
    .entry_count_o (entry_count_o),
    .mode_o        (mode_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Lock state as the testbench tracks it
  logic [ModeW-1:0]  lock_mode;
  code_t             entry_code;
  code_t             stored_code;
  code_t             new_code;
  logic [CntW-1:0]   entry_len;
  logic [CntW-1:0]   stored_len;
  logic [CntW-1:0]   new_len;
  logic [RetryW-1:0] fail_count;
  logic [RetryW-1:0] alarm_limit;

  lock_word_t lock_words_q [$];
  int answered_keys  = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  task automatic lock_reset();
    lock_mode      = ModeMenu;
    entry_code     = '0;
    entry_len      = '0;
    stored_code    = '0;
    stored_code[0] = 4'd1;
    stored_code[1] = 4'd2;
    stored_code[2] = 4'd3;
    stored_code[3] = 4'd4;
    stored_len     = CntW'(4);
    new_code       = '0;
    new_len        = '0;
    fail_count     = '0;
    alarm_limit    = RetryLimitReset;
  endtask

  // Digits the current entry has to reach
  function automatic int entry_target();
    int n;
    n = (lock_mode == ModeNew || lock_mode == ModeConf) ? int'(new_len) : int'(stored_len);
    return (n > MaxDigits) ? MaxDigits : n;
  endfunction

  function automatic bit code_matches(input code_t a, input code_t b, input int n);
    for (int i = 0; i < n; i++) begin
      if (a[i] != b[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic code_t random_code();
    code_t c;
    for (int i = 0; i < MaxDigits; i++) c[i] = KeyW'($urandom_range(9));
    return c;
  endfunction

  // Advance the tracked lock by one key and form its result word
  task automatic predict_key(input logic [KeyW-1:0] k, output lock_word_t r);
    int                target;
    logic [EventW-1:0] ev;
    logic [RetryW-1:0] shown;
    ev     = EvIgnored;
    target = entry_target();
    case (lock_mode)
      ModeMenu: begin
        if (k == KeyA) begin
          lock_mode = ModeOld;
          entry_len = '0;
          ev        = EvChange;
        end else if (k == KeyHash) begin
          lock_mode = ModeLogin;
          entry_len = '0;
          ev        = EvLogin;
        end
      end
      ModeLen: begin
        if (k >= LenKeyLo && k <= LenKeyHi) begin
          new_len   = CntW'(k);
          entry_len = '0;
          lock_mode = ModeNew;
          ev        = EvLength;
        end
      end
      ModeLogin, ModeOld, ModeNew, ModeConf: begin
        if (k <= KeyDigitMax) begin
          if (entry_len < target) begin
            entry_code[entry_len] = k;
            entry_len++;
            ev = EvDigit;
          end
        end else if (k == KeyStar) begin
          if (entry_len > 0) begin
            entry_len--;
            ev = EvErased;
          end
        end else if (k == KeyHash && entry_len >= target) begin
          entry_len = '0;
          case (lock_mode)
            ModeLogin: begin
              lock_mode = ModeMenu;
              if (code_matches(stored_code, entry_code, target)) begin
                fail_count = '0;
                ev         = EvGranted;
              end else begin
                if (fail_count < RetryMax) fail_count++;
                ev = (fail_count >= alarm_limit) ? EvAlarm : EvWrong;
              end
            end
            ModeOld: begin
              if (code_matches(stored_code, entry_code, target)) begin
                lock_mode = ModeLen;
                ev        = EvChange;
              end else begin
                lock_mode = ModeMenu;
                ev        = EvOldBad;
              end
            end
            ModeNew: begin
              new_code  = entry_code;
              lock_mode = ModeConf;
              ev        = EvConfirm;
            end
            default: begin
              lock_mode = ModeMenu;
              if (code_matches(new_code, entry_code, target)) begin
                stored_code = new_code;
                stored_len  = CntW'(target);
                ev          = EvSaved;
              end else begin
                ev = EvMismatch;
              end
            end
          endcase
        end
      end
      default: lock_mode = ModeMenu;
    endcase
    shown = fail_count;
    if (ev == EvAlarm) fail_count = '0;
    r = '{ev, shown, entry_len, lock_mode};
  endtask

  // Present one key word, wait for it to be taken, then log its expected result
  task automatic send_key(input logic [KeyW-1:0] k);
    lock_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i      <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_key(k, r);
    lock_words_q.push_back(r);
    answered_keys++;
  endtask

  // Key in a code, now and then with a typo fixed by erase or an early enter
  task automatic send_digits(input code_t c, input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(11))
        0: begin
          send_key(KeyW'($urandom_range(9)));
          send_key(KeyStar);
        end
        1: send_key(KeyHash);
        default: ;
      endcase
      send_key(c[i]);
    end
    // digit past a full entry is dropped
    if ($urandom_range(7) == 0) send_key(KeyW'($urandom_range(9)));
  endtask

  task automatic login_session(input bit right);
    code_t c;
    c = right ? stored_code : random_code();
    send_key(KeyHash);
    send_digits(c, int'(stored_len));
    send_key(KeyHash);
  endtask

  task automatic change_session();
    code_t           c;
    logic [KeyW-1:0] len_key;
    send_key(KeyA);
    c = ($urandom_range(99) < 85) ? stored_code : random_code();
    send_digits(c, int'(stored_len));
    send_key(KeyHash);
    if (lock_mode != ModeLen) return;
    // an unusable length key first, sometimes
    len_key = KeyW'($urandom_range(15));
    if ($urandom_range(3) == 0 && (len_key < LenKeyLo || len_key > LenKeyHi)) send_key(len_key);
    send_key(KeyW'($urandom_range(LenKeyLo, LenKeyHi)));
    c = random_code();
    send_digits(c, int'(new_len));
    send_key(KeyHash);
    if ($urandom_range(99) >= 80) c = random_code();
    send_digits(c, int'(new_len));
    send_key(KeyHash);
  endtask

  // Finish whatever entry is open so the next session starts from the menu
  task automatic back_to_menu();
    while (lock_mode != ModeMenu) begin
      if (lock_mode == ModeLen) send_key(KeyW'(LenKeyLo));
      else if (entry_len < entry_target()) send_key(KeyW'($urandom_range(9)));
      else send_key(KeyHash);
    end
  endtask

  // Limit writes only once every result word is back
  task automatic write_limit(input logic [RetryW-1:0] v);
    in_valid_i <= 1'b0;
    while (lock_words_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    alarm_limit = v;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side: check each taken word, stall at random
  always @(posedge clk_i) begin
    lock_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lock_words_q.size() == 0) begin
        $error("result word with none expected: event_res %0d", event_res_o);
        errors++;
      end else begin
        want = lock_words_q.pop_front();
        compare_field("event_res", want.ev, event_res_o);
        compare_field("retry_count", want.retries, retry_count_o);
        compare_field("entry_count", want.entries, entry_count_o);
        compare_field("mode", want.mode, mode_o);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int goal;
    int pick;
    lock_reset();
    send_idle_pct  = SendIdle[0];
    recv_stall_pct = RecvStall[0];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset limit
    for (int i = 0; i < NumKeyRows; i++) begin
      send_key(KeyRows[i].key);
      if (KeyRows[i].typed) lock_words_q[lock_words_q.size() - 1] = KeyRows[i].want;
    end

    // Random sessions, one limit setting per phase
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(PhaseLimit[p]);
      send_idle_pct  = SendIdle[p / 2];
      recv_stall_pct = RecvStall[p / 2];
      goal = answered_keys + PhaseWords;
      while (answered_keys < goal) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          repeat ($urandom_range(1, 6)) send_key(KeyW'($urandom_range(15)));
        end else begin
          back_to_menu();
          if (pick < 55) login_session($urandom_range(99) < PhaseGrant[p]);
          else change_session();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (lock_words_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
